@@ src/mahs_pkg.sv @@
package mahs_pkg;

   localparam int AXIS_W = 2;
   localparam int MAX_AXES = 4;

   localparam logic [63:0] RESET_SPEEDS = 64'h03E8_07D0_07D0_07D0;
   localparam logic [63:0] RESET_BACKOFF = 64'h00C8_0190_0190_0190;
   localparam logic [3:0] RESET_DIR_MASK = 4'hF;
   localparam logic [7:0] RESET_DEBOUNCE = 8'd3;

   // Reciprocal of three in 17 fractional bits, exact for 16-bit dividends.
   localparam logic [15:0] THIRD_RECIP = 16'hAAAB;

   localparam logic [1:0] REG_DIR_MASK = 2'd0;
   localparam logic [1:0] REG_SEEK_SPEEDS = 2'd1;
   localparam logic [1:0] REG_BACKOFF = 2'd2;
   localparam logic [1:0] REG_DEBOUNCE = 2'd3;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_SET   = 2'd2,
      MODE_ABORT = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_SEEK = 3'd1,
      PH_TRIG = 3'd2,
      PH_BACK = 3'd3,
      PH_SETZ = 3'd4,
      PH_DONE = 3'd5,
      PH_FAIL = 3'd6
   } phase_type;

   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_RUN  = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic last;
      logic [AXIS_W-1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic single;
   } sts_type;

   function automatic logic is_active(phase_type p);
      return (p == PH_SEEK) || (p == PH_TRIG) || (p == PH_BACK) || (p == PH_SETZ);
   endfunction

endpackage

@@ src/mahs_req_if.sv @@
interface mahs_req_if;
   logic valid;
   logic ready;
   logic [1:0] mode;
   logic [1:0] axis_select;
   logic signed [31:0] offset_value;
   logic probe_level;
   logic estop_active;
   logic fault_active;
   logic signed [31:0] position_0;
   logic signed [31:0] position_1;
   logic signed [31:0] position_2;
   logic signed [31:0] position_3;

   modport source (
      output valid, mode, axis_select, offset_value, probe_level, estop_active,
         fault_active, position_0, position_1, position_2, position_3,
      input ready
   );
   modport sink (
      input valid, mode, axis_select, offset_value, probe_level, estop_active,
         fault_active, position_0, position_1, position_2, position_3,
      output ready
   );
endinterface

@@ src/mahs_rsp_if.sv @@
interface mahs_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] axis_index;
   logic command_valid;
   logic signed [16:0] drive_speed;
   logic [2:0] axis_state;
   logic signed [31:0] axis_offset;
   logic [3:0] homed_flags;
   logic status;
   logic persist_offset;
   logic last;

   modport source (
      output valid, axis_index, command_valid, drive_speed, axis_state, axis_offset,
         homed_flags, status, persist_offset, last,
      input ready
   );
   modport sink (
      input valid, axis_index, command_valid, drive_speed, axis_state, axis_offset,
         homed_flags, status, persist_offset, last,
      output ready
   );
endinterface

@@ src/mahs_csr_if.sv @@
interface mahs_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/mahs_ctrl.sv @@
module mahs_ctrl
   import mahs_pkg::*;
#(
   parameter int AXES_USED = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    req_ready,
   output logic    rsp_valid
);

   localparam int AXW = (AXES_USED > 1) ? $clog2(AXES_USED) : 1;

   ctrl_state_type state_ff, state_in;
   logic [AXW-1:0] axis_ff, axis_in;
   logic out_valid_ff, out_valid_in;
   logic advance;
   logic final_axis;

   assign advance = (state_ff == CS_RUN) && (!out_valid_ff || rsp_ready);
   assign final_axis = sts.single || (axis_ff == AXW'(AXES_USED - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) state_in = CS_RUN;
         end
         CS_RUN: begin
            if (advance && final_axis) state_in = CS_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         CS_RUN: begin
            cmd.eval = advance;
            cmd.last = final_axis;
            cmd.axis = AXIS_W'(axis_ff);
         end
      endcase
   end

   always_comb begin
      axis_in = axis_ff;
      if (cmd.load) begin
         axis_in = '0;
      end else if (advance && !final_axis) begin
         axis_in = axis_ff + AXW'(1);
      end
   end

   // The result register is refilled in the cycle it is taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         axis_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff <= axis_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

@@ src/mahs_dp.sv @@
module mahs_dp
   import mahs_pkg::*;
#(
   parameter int AXES_USED = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   mahs_req_if.sink    req_chan,
   mahs_csr_if.sink    csr_chan,
   mahs_rsp_if.source  rsp_chan
);

   localparam int AXW = (AXES_USED > 1) ? $clog2(AXES_USED) : 1;

   // Latched request.
   mode_type mode_ff;
   logic [1:0] sel_ff;
   logic signed [31:0] offv_ff;
   logic probe_ff;
   logic halt_ff;
   logic signed [31:0] pos_ff [AXES_USED];
   logic signed [31:0] pos_in [MAX_AXES];

   // Configuration.
   logic [3:0] dir_ff;
   logic [63:0] speeds_ff;
   logic [63:0] backoff_ff;
   logic [7:0] deb_ticks_ff;

   // Per-axis state.
   phase_type phase_ff [AXES_USED];
   logic [7:0] deb_ff [AXES_USED];
   logic signed [31:0] origin_ff [AXES_USED];
   logic signed [31:0] offset_ff [AXES_USED];
   logic neg_ff [AXES_USED];
   logic [3:0] homed_ff;

   // Result register.
   logic [1:0] out_axis_ff;
   logic out_cv_ff;
   logic signed [16:0] out_spd_ff;
   phase_type out_state_ff;
   logic signed [31:0] out_offset_ff;
   logic [3:0] out_homed_ff;
   logic out_status_ff;
   logic out_persist_ff;
   logic out_last_ff;

   // Evaluation of one axis.
   logic [1:0] tgt;
   logic [AXW-1:0] idx;
   logic in_range;
   logic any_active;
   phase_type cur_phase, ph_new;
   logic [7:0] cur_deb, deb_new, deb_inc;
   logic cur_neg, neg_new;
   logic signed [31:0] cur_off, off_new;
   logic signed [31:0] cur_pos;
   logic [3:0] homed_new;
   logic org_wr;
   logic cv;
   logic signed [16:0] spd;
   logic st;
   logic persist;
   logic [15:0] speed, steps;
   logic [31:0] third_prod;
   logic signed [16:0] seek_spd, back_spd;
   logic signed [32:0] delta;
   logic signed [33:0] travel;

   assign pos_in[0] = req_chan.position_0;
   assign pos_in[1] = req_chan.position_1;
   assign pos_in[2] = req_chan.position_2;
   assign pos_in[3] = req_chan.position_3;

   assign sts.single = (mode_ff == MODE_START) || (mode_ff == MODE_SET);
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode_type'(req_chan.mode);
         sel_ff <= req_chan.axis_select;
         offv_ff <= req_chan.offset_value;
         probe_ff <= req_chan.probe_level;
         halt_ff <= req_chan.estop_active || req_chan.fault_active;
         for (int a = 0; a < AXES_USED; a++) begin
            pos_ff[a] <= pos_in[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= RESET_DIR_MASK;
         speeds_ff <= RESET_SPEEDS;
         backoff_ff <= RESET_BACKOFF;
         deb_ticks_ff <= RESET_DEBOUNCE;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_DIR_MASK:    dir_ff <= csr_chan.data[3:0];
            REG_SEEK_SPEEDS: speeds_ff <= csr_chan.data;
            REG_BACKOFF:     backoff_ff <= csr_chan.data;
            REG_DEBOUNCE:    deb_ticks_ff <= csr_chan.data[7:0];
         endcase
      end
   end

   always_comb begin
      any_active = 1'b0;
      for (int a = 0; a < AXES_USED; a++) begin
         if (is_active(phase_ff[a])) any_active = 1'b1;
      end
   end

   assign tgt = sts.single ? sel_ff : cmd.axis;
   assign idx = tgt[AXW-1:0];
   assign in_range = {1'b0, tgt} < 3'(AXES_USED);

   assign speed = speeds_ff[{tgt, 4'b0000} +: 16];
   assign steps = backoff_ff[{tgt, 4'b0000} +: 16];
   assign third_prod = speed * THIRD_RECIP;
   assign seek_spd = cur_neg ? -$signed({1'b0, speed}) : $signed({1'b0, speed});
   assign back_spd = cur_neg ? $signed({2'b00, third_prod[31:17]})
                             : -$signed({2'b00, third_prod[31:17]});

   always_comb begin
      cur_phase = PH_IDLE;
      cur_deb = '0;
      cur_neg = 1'b0;
      cur_off = '0;
      cur_pos = '0;
      if (in_range) begin
         cur_phase = phase_ff[idx];
         cur_deb = deb_ff[idx];
         cur_neg = neg_ff[idx];
         cur_off = offset_ff[idx];
         cur_pos = pos_ff[idx];
      end
   end

   // Backoff travel is counted in the direction away from the switch.
   assign delta = $signed({cur_pos[31], cur_pos}) - $signed({origin_ff[idx][31], origin_ff[idx]});
   assign travel = cur_neg ? $signed({delta[32], delta}) : -$signed({delta[32], delta});
   assign deb_inc = (cur_deb != 8'hFF) ? cur_deb + 8'd1 : cur_deb;

   always_comb begin
      ph_new = cur_phase;
      deb_new = cur_deb;
      neg_new = cur_neg;
      off_new = cur_off;
      homed_new = homed_ff;
      org_wr = 1'b0;
      cv = 1'b0;
      spd = '0;
      st = 1'b0;
      persist = 1'b0;
      priority if (mode_ff == MODE_START) begin
         if (in_range && !halt_ff && !any_active) begin
            ph_new = PH_SEEK;
            neg_new = dir_ff[tgt];
            deb_new = '0;
         end else begin
            st = 1'b1;
         end
      end else if (mode_ff == MODE_SET) begin
         if (in_range) begin
            off_new = offv_ff;
            homed_new = homed_ff | (4'b0001 << tgt);
            ph_new = PH_DONE;
         end
      end else if ((mode_ff == MODE_ABORT) || halt_ff) begin
         if (is_active(cur_phase)) begin
            ph_new = PH_IDLE;
            cv = 1'b1;
         end
      end else begin
         unique case (cur_phase)
            PH_SEEK: begin
               cv = 1'b1;
               spd = seek_spd;
               if (!probe_ff) begin
                  deb_new = deb_inc;
                  if (deb_inc >= deb_ticks_ff) begin
                     spd = '0;
                     ph_new = PH_TRIG;
                  end
               end else begin
                  deb_new = '0;
               end
            end
            PH_TRIG: begin
               org_wr = 1'b1;
               ph_new = PH_BACK;
            end
            PH_BACK: begin
               cv = 1'b1;
               spd = back_spd;
               if (travel >= $signed({18'b0, steps})) begin
                  spd = '0;
                  ph_new = PH_SETZ;
               end
            end
            PH_SETZ: begin
               off_new = cur_pos;
               homed_new = homed_ff | (4'b0001 << tgt);
               ph_new = PH_DONE;
               persist = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         homed_ff <= '0;
         for (int a = 0; a < AXES_USED; a++) begin
            phase_ff[a] <= PH_IDLE;
            deb_ff[a] <= '0;
            offset_ff[a] <= '0;
            neg_ff[a] <= 1'b0;
         end
      end else if (cmd.eval) begin
         homed_ff <= homed_new;
         if (in_range) begin
            phase_ff[idx] <= ph_new;
            deb_ff[idx] <= deb_new;
            offset_ff[idx] <= off_new;
            neg_ff[idx] <= neg_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval && in_range && org_wr) begin
         origin_ff[idx] <= cur_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         out_axis_ff <= tgt;
         out_cv_ff <= cv;
         out_spd_ff <= spd;
         out_state_ff <= ph_new;
         out_offset_ff <= off_new;
         out_homed_ff <= homed_new;
         out_status_ff <= st;
         out_persist_ff <= persist;
         out_last_ff <= cmd.last;
      end
   end

   assign rsp_chan.axis_index = out_axis_ff;
   assign rsp_chan.command_valid = out_cv_ff;
   assign rsp_chan.drive_speed = out_spd_ff;
   assign rsp_chan.axis_state = out_state_ff;
   assign rsp_chan.axis_offset = out_offset_ff;
   assign rsp_chan.homed_flags = out_homed_ff;
   assign rsp_chan.status = out_status_ff;
   assign rsp_chan.persist_offset = out_persist_ff;
   assign rsp_chan.last = out_last_ff;

endmodule

@@ src/multi_axis_homing_sequencer.sv @@
// A request is latched when it is accepted in the idle state; the controller then steps
// the single axis update unit through its axes and registers each result. A tick or abort
// request gives one result per axis, one per cycle while the receiver takes them; start and
// set-offset give one result. No new request is taken until the last one has been evaluated.
// Reset clears every axis to idle, offsets and homed bits to zero, and loads the
// default direction mask, seek speeds, backoff distances and debounce count.
module multi_axis_homing_sequencer
   import mahs_pkg::*;
#(
   parameter int NUM_AXES = 4
) (
   input  logic       clock,
   input  logic       reset,
   mahs_req_if.sink   req_chan,
   mahs_rsp_if.source rsp_chan,
   mahs_csr_if.sink   csr_chan
);

   localparam int AXES_USED = (NUM_AXES > MAX_AXES) ? MAX_AXES : NUM_AXES;

   cmd_type cmd;
   sts_type sts;
   logic req_ready;
   logic rsp_valid;

   mahs_ctrl #(
      .AXES_USED(AXES_USED)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .sts(sts),
      .cmd(cmd),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid)
   );

   mahs_dp #(
      .AXES_USED(AXES_USED)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_chan(req_chan),
      .csr_chan(csr_chan),
      .rsp_chan(rsp_chan)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

@@ bench/homing_checker.sv @@
`timescale 1ns / 1ps

module homing_checker
   import mahs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mahs_req_if  req,
   mahs_rsp_if  rsp,
   mahs_csr_if  csr,
   output int   fail_count,
   output int   outstanding,
   output int   request_count,
   output int   result_count,
   output int   persist_count,
   output int   refused_count
);

   typedef struct packed {
      logic [1:0]  axis;
      logic        command;
      logic [16:0] speed;
      logic [2:0]  state;
      logic [31:0] offset;
      logic [3:0]  homed;
      logic        status;
      logic        persist;
      logic        last;
   } axis_report_type;

   axis_report_type reports_due[$];

   phase_type   axis_phase [4];
   logic [7:0]  debounce_run [4];
   longint      origin_pos [4];
   logic [31:0] home_pos [4];
   logic [3:0]  homed_bits;
   logic [3:0]  seek_neg;

   logic [3:0]  dir_mask;
   logic [63:0] seek_speeds;
   logic [63:0] backoff_steps;
   logic [7:0]  debounce_limit;

   int mismatches = 0;
   int requests = 0;
   int results = 0;
   int persists = 0;
   int refusals = 0;

   function automatic string describe(axis_report_type r);
      return {$sformatf("axis=%0d cmd=%0b speed=%0d state=%0d offset=%h homed=%h",
                        r.axis, r.command, $signed(r.speed), r.state, r.offset, r.homed),
              $sformatf(" status=%0b persist=%0b last=%0b", r.status, r.persist, r.last)};
   endfunction

   function automatic logic any_axis_busy();
      int a;
      for (a = 0; a < MAX_AXES; a++) begin
         if (axis_phase[a] >= PH_SEEK && axis_phase[a] <= PH_SETZ) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic reset_model();
      int a;
      for (a = 0; a < MAX_AXES; a++) begin
         axis_phase[a] = PH_IDLE;
         debounce_run[a] = '0;
         origin_pos[a] = 0;
         home_pos[a] = '0;
      end
      homed_bits = '0;
      seek_neg = '0;
      dir_mask = RESET_DIR_MASK;
      seek_speeds = RESET_SPEEDS;
      backoff_steps = RESET_BACKOFF;
      debounce_limit = RESET_DEBOUNCE;
      reports_due.delete();
   endtask

   task automatic push_report(int a, logic cmd, int spd, logic st, logic persist, logic last);
      axis_report_type r;
      r.axis = a[1:0];
      r.command = cmd;
      r.speed = spd[16:0];
      r.state = axis_phase[a];
      r.offset = home_pos[a];
      r.homed = homed_bits;
      r.status = st;
      r.persist = persist;
      r.last = last;
      reports_due.push_back(r);
      if (persist) persists++;
      if (st) refusals++;
   endtask

   task automatic apply_register();
      case (csr.index)
         REG_DIR_MASK:    dir_mask = csr.data[3:0];
         REG_SEEK_SPEEDS: seek_speeds = csr.data;
         REG_BACKOFF:     backoff_steps = csr.data;
         REG_DEBOUNCE:    debounce_limit = csr.data[7:0];
         default: ;
      endcase
   endtask

   task automatic predict_request();
      logic [31:0] pos [4];
      logic        halt;
      logic        probe_low;
      logic        cmd;
      logic        persist;
      logic        status_bit;
      logic [1:0]  sel;
      mode_type    mode;
      int          a;
      int          spd;
      int          speed;
      int          bo_len;
      longint      travel;

      mode = mode_type'(req.mode);
      sel = req.axis_select;
      halt = req.estop_active | req.fault_active;
      probe_low = ~req.probe_level;
      pos[0] = req.position_0;
      pos[1] = req.position_1;
      pos[2] = req.position_2;
      pos[3] = req.position_3;
      requests++;

      if (mode == MODE_START) begin
         status_bit = 1'b1;
         if (!halt && !any_axis_busy()) begin
            axis_phase[sel] = PH_SEEK;
            seek_neg[sel] = dir_mask[sel];
            debounce_run[sel] = '0;
            status_bit = 1'b0;
         end
         push_report(int'(sel), 1'b0, 0, status_bit, 1'b0, 1'b1);
      end else if (mode == MODE_SET) begin
         // A direct offset write finishes the axis whatever it was doing.
         home_pos[sel] = req.offset_value;
         homed_bits[sel] = 1'b1;
         axis_phase[sel] = PH_DONE;
         push_report(int'(sel), 1'b0, 0, 1'b0, 1'b0, 1'b1);
      end else if (mode == MODE_ABORT || halt) begin
         for (a = 0; a < MAX_AXES; a++) begin
            cmd = 1'b0;
            if (axis_phase[a] >= PH_SEEK && axis_phase[a] <= PH_SETZ) begin
               axis_phase[a] = PH_IDLE;
               cmd = 1'b1;
            end
            push_report(a, cmd, 0, 1'b0, 1'b0, a == MAX_AXES - 1);
         end
      end else begin
         for (a = 0; a < MAX_AXES; a++) begin
            speed = int'(seek_speeds[16*a +: 16]);
            bo_len = int'(backoff_steps[16*a +: 16]);
            cmd = 1'b0;
            persist = 1'b0;
            spd = 0;
            case (axis_phase[a])
               PH_SEEK: begin
                  cmd = 1'b1;
                  spd = seek_neg[a] ? -speed : speed;
                  if (probe_low) begin
                     if (debounce_run[a] != 8'hFF) debounce_run[a] = debounce_run[a] + 8'd1;
                     if (debounce_run[a] >= debounce_limit) begin
                        spd = 0;
                        axis_phase[a] = PH_TRIG;
                     end
                  end else begin
                     debounce_run[a] = '0;
                  end
               end
               PH_TRIG: begin
                  origin_pos[a] = longint'($signed(pos[a]));
                  axis_phase[a] = PH_BACK;
               end
               PH_BACK: begin
                  // Travel counts positive in the direction away from the switch.
                  travel = longint'($signed(pos[a])) - origin_pos[a];
                  if (!seek_neg[a]) travel = -travel;
                  cmd = 1'b1;
                  spd = seek_neg[a] ? speed / 3 : -(speed / 3);
                  if (travel >= longint'(bo_len)) begin
                     spd = 0;
                     axis_phase[a] = PH_SETZ;
                  end
               end
               PH_SETZ: begin
                  home_pos[a] = pos[a];
                  homed_bits[a] = 1'b1;
                  axis_phase[a] = PH_DONE;
                  persist = 1'b1;
               end
               default: ;
            endcase
            push_report(a, cmd, spd, 1'b0, persist, a == MAX_AXES - 1);
         end
      end
   endtask

   task automatic check_report();
      axis_report_type seen;
      axis_report_type want;

      seen.axis = rsp.axis_index;
      seen.command = rsp.command_valid;
      seen.speed = rsp.drive_speed;
      seen.state = rsp.axis_state;
      seen.offset = rsp.axis_offset;
      seen.homed = rsp.homed_flags;
      seen.status = rsp.status;
      seen.persist = rsp.persist_offset;
      seen.last = rsp.last;
      results++;
      if (reports_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t homing_checker: result with nothing pending: %s", $realtime,
                     describe(seen));
         end
      end else begin
         want = reports_due.pop_front();
         if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t homing_checker: mismatch", $realtime);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(seen));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
      end else begin
         if (rsp.valid && rsp.ready) check_report();
         if (csr.valid && csr.ready) apply_register();
         if (req.valid && req.ready) predict_request();
      end
      fail_count <= mismatches;
      outstanding <= reports_due.size();
      request_count <= requests;
      result_count <= results;
      persist_count <= persists;
      refused_count <= refusals;
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import mahs_pkg::*;

   typedef struct packed {
      mode_type         mode;
      logic [1:0]       axis;
      logic [31:0]      offset;
      logic             probe;
      logic             estop;
      logic             fault;
      logic [3:0][31:0] pos;
   } homing_req_type;

   logic clock;
   logic reset;

   int send_idle_pct = 21;
   int recv_idle_pct = 71;
   int sent_count = 0;

   // Copies of the programmed direction, backoff and debounce registers, used to shape homing sequences.
   logic [3:0]  dir_cfg = RESET_DIR_MASK;
   logic [63:0] dist_cfg = RESET_BACKOFF;
   logic [7:0]  deb_cfg = RESET_DEBOUNCE;

   int fail_count;
   int outstanding;
   int request_count;
   int result_count;
   int persist_count;
   int refused_count;

   mahs_req_if req_bus ();
   mahs_rsp_if rsp_bus ();
   mahs_csr_if csr_bus ();

   multi_axis_homing_sequencer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   homing_checker homing_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_bus),
      .rsp           (rsp_bus),
      .csr           (csr_bus),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .request_count (request_count),
      .result_count  (result_count),
      .persist_count (persist_count),
      .refused_count (refused_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic homing_req_type random_tick(logic probe);
      homing_req_type r;
      int i;
      r.mode = MODE_TICK;
      r.axis = 2'($urandom_range(3));
      r.offset = $urandom();
      r.probe = probe;
      r.estop = 1'b0;
      r.fault = 1'b0;
      for (i = 0; i < 4; i++) r.pos[i] = $urandom();
      return r;
   endfunction

   function automatic homing_req_type make_req(mode_type mode, logic [1:0] axis, logic probe,
                                               logic estop, logic fault);
      homing_req_type r;
      r = random_tick(probe);
      r.mode = mode;
      r.axis = axis;
      r.estop = estop;
      r.fault = fault;
      return r;
   endfunction

   task automatic send_request(input homing_req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= r.mode;
      req_bus.axis_select <= r.axis;
      req_bus.offset_value <= r.offset;
      req_bus.probe_level <= r.probe;
      req_bus.estop_active <= r.estop;
      req_bus.fault_active <= r.fault;
      req_bus.position_0 <= r.pos[0];
      req_bus.position_1 <= r.pos[1];
      req_bus.position_2 <= r.pos[2];
      req_bus.position_3 <= r.pos[3];
      do @(posedge clock); while (!req_bus.ready);
      sent_count++;
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_register(logic [1:0] index, logic [63:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic program_axes(logic [3:0] dirs, logic [63:0] speeds, logic [63:0] dists,
                               logic [7:0] deb);
      write_register(REG_DIR_MASK, {60'd0, dirs});
      write_register(REG_SEEK_SPEEDS, speeds);
      write_register(REG_BACKOFF, dists);
      write_register(REG_DEBOUNCE, {56'd0, deb});
      csr_bus.valid <= 1'b0;
      dir_cfg = dirs;
      dist_cfg = dists;
      deb_cfg = deb;
   endtask

   // Ends a homing run early with an abort request, an estop tick or a fault tick.
   task automatic interrupt_homing();
      case ($urandom_range(2))
         0: send_request(make_req(MODE_ABORT, 2'($urandom_range(3)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 1'($urandom_range(1))));
         1: send_request(make_req(MODE_TICK, 2'd0, 1'($urandom_range(1)), 1'b1,
                                  1'($urandom_range(1))));
         default: send_request(make_req(MODE_TICK, 2'd0, 1'($urandom_range(1)), 1'b0, 1'b1));
      endcase
   endtask

   // One homing run on a random axis, sometimes cut short: seek, debounce, trigger, back off, record.
   task automatic run_homing();
      homing_req_type r;
      int          axn;
      int          span;
      int          lows;
      int          needed;
      int          part;
      int          break_at;
      logic        neg;
      logic [31:0] rnd;
      logic [31:0] origin;

      axn = $urandom_range(3);
      neg = dir_cfg[axn];
      span = int'(dist_cfg[16*axn +: 16]);
      break_at = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0;

      r = make_req(MODE_START, 2'(axn), 1'b1, 1'b0, 1'b0);
      send_request(r);
      repeat ($urandom_range(2)) send_request(random_tick(1'b1));
      if (break_at == 1) begin
         interrupt_homing();
         return;
      end

      needed = (deb_cfg == 0) ? 1 : int'(deb_cfg);
      if (needed >= 2 && $urandom_range(2) == 0) begin
         send_request(random_tick(1'b0));
         send_request(random_tick(1'b1));
      end
      lows = (needed > 8) ? 8 : needed;
      repeat (lows) send_request(random_tick(1'b0));
      if (lows < needed || break_at == 2) begin
         interrupt_homing();
         return;
      end

      rnd = $urandom();
      origin = {rnd[31], rnd[31:1]};
      r = random_tick(1'($urandom_range(1)));
      r.pos[axn] = origin;
      send_request(r);
      if (span > 0) begin
         repeat ($urandom_range(2)) begin
            part = $urandom_range(span - 1);
            r = random_tick(1'($urandom_range(1)));
            r.pos[axn] = neg ? origin + 32'(part) : origin - 32'(part);
            send_request(r);
         end
      end
      if (break_at == 3) begin
         interrupt_homing();
         return;
      end
      part = span + $urandom_range(3);
      r = random_tick(1'($urandom_range(1)));
      r.pos[axn] = neg ? origin + 32'(part) : origin - 32'(part);
      send_request(r);
      send_request(random_tick(1'($urandom_range(1))));
   endtask

   initial begin
      homing_req_type r;
      int chunk;

      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.mode <= MODE_TICK;
      req_bus.axis_select <= '0;
      req_bus.offset_value <= '0;
      req_bus.probe_level <= 1'b1;
      req_bus.estop_active <= 1'b0;
      req_bus.fault_active <= 1'b0;
      req_bus.position_0 <= '0;
      req_bus.position_1 <= '0;
      req_bus.position_2 <= '0;
      req_bus.position_3 <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= REG_DIR_MASK;
      csr_bus.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset register values.
      r = make_req(MODE_TICK, 2'd0, 1'b1, 1'b0, 1'b0);
      r.pos = '0;
      send_request(r);
      r = make_req(MODE_SET, 2'd3, 1'b1, 1'b0, 1'b0);
      r.offset = 32'h8000_0000;
      send_request(r);
      // A direct offset write is honored even under estop and fault.
      r = make_req(MODE_SET, 2'd0, 1'b0, 1'b1, 1'b1);
      r.offset = 32'h7FFF_FFFF;
      send_request(r);
      send_request(make_req(MODE_START, 2'd1, 1'b1, 1'b1, 1'b0));
      send_request(make_req(MODE_START, 2'd2, 1'b1, 1'b0, 1'b1));
      send_request(make_req(MODE_START, 2'd1, 1'b1, 1'b0, 1'b0));
      send_request(make_req(MODE_START, 2'd2, 1'b1, 1'b0, 1'b0));
      send_request(random_tick(1'b0));
      send_request(random_tick(1'b1));
      repeat (3) send_request(random_tick(1'b0));
      r = random_tick(1'b1);
      r.pos[1] = 32'h8000_0000;
      send_request(r);
      r = random_tick(1'b0);
      r.pos[1] = 32'h8000_0064;
      send_request(r);
      r = random_tick(1'b1);
      r.pos[1] = 32'h8000_0190;
      send_request(r);
      r = random_tick(1'b1);
      r.pos = {4{32'hFFFF_FFFF}};
      r.pos[1] = 32'h7FFF_FFFF;
      send_request(r);
      send_request(make_req(MODE_START, 2'd3, 1'b1, 1'b0, 1'b0));
      send_request(random_tick(1'b0));
      send_request(make_req(MODE_TICK, 2'd0, 1'b0, 1'b0, 1'b1));
      send_request(make_req(MODE_START, 2'd2, 1'b1, 1'b0, 1'b0));
      send_request(make_req(MODE_TICK, 2'd0, 1'b1, 1'b1, 1'b1));
      send_request(make_req(MODE_START, 2'd0, 1'b1, 1'b0, 1'b0));
      send_request(make_req(MODE_SET, 2'd0, 1'b1, 1'b0, 1'b0));
      send_request(make_req(MODE_ABORT, 2'd0, 1'b1, 1'b1, 1'b0));
      send_request(make_req(MODE_START, 2'd2, 1'b1, 1'b0, 1'b0));
      send_request(make_req(MODE_ABORT, 2'd1, 1'b0, 1'b0, 1'b0));

      for (chunk = 0; chunk < 6; chunk++) begin
         wait_for_drain();
         if (chunk == 2) begin
            send_idle_pct = 71;
            recv_idle_pct <= 21;
         end else if (chunk == 4) begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         case (chunk)
            0: program_axes(4'h0, 64'hFFFF_0000_FFFF_0001, 64'h0000_FFFF_0001_0003, 8'd1);
            1: program_axes(4'hF, {$urandom(), $urandom()},
                            {16'($urandom_range(40)), 16'($urandom_range(40)),
                             16'($urandom_range(40)), 16'($urandom_range(40))}, 8'd255);
            2: program_axes(4'hA, {$urandom(), $urandom()}, {$urandom(), $urandom()}, 8'd0);
            3: program_axes(4'($urandom()), {$urandom(), $urandom()},
                            {$urandom(), $urandom()}, 8'($urandom_range(1, 4)));
            4: program_axes(4'h5, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd2);
            default: program_axes(4'($urandom()), {$urandom(), $urandom()},
                                  {$urandom(), $urandom()}, 8'($urandom_range(1, 6)));
         endcase
         while (sent_count < 25 + 42 * (chunk + 1)) begin
            if ($urandom_range(3) == 0) begin
               // Unstructured requests, then an abort so that no axis stays stuck.
               repeat ($urandom_range(2, 6)) begin
                  r = random_tick(1'($urandom_range(1)));
                  r.mode = mode_type'($urandom_range(3));
                  r.estop = ($urandom_range(7) == 0);
                  r.fault = ($urandom_range(7) == 0);
                  send_request(r);
               end
               send_request(make_req(MODE_ABORT, 2'($urandom_range(3)),
                                     1'($urandom_range(1)), 1'($urandom_range(1)),
                                     1'($urandom_range(1))));
            end else begin
               run_homing();
            end
         end
      end

      wait_for_drain();
      repeat (10) @(posedge clock);
      $display("Summary: %0d requests gave %0d checked results over seven register settings,",
               request_count, result_count);
      $display("with %0d home offsets recorded and %0d starts refused.",
               persist_count, refused_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/mahs_pkg.sv
src/mahs_req_if.sv
src/mahs_rsp_if.sv
src/mahs_csr_if.sv
src/mahs_ctrl.sv
src/mahs_dp.sv
src/multi_axis_homing_sequencer.sv
bench/homing_checker.sv
bench/testbench.sv
